// ----- hw/rtl/mac_data_frame_builder_macros.svh -----
// Assertion macros used by the frame builder RTL.
`ifndef MAC_DATA_FRAME_BUILDER_MACROS_SVH
`define MAC_DATA_FRAME_BUILDER_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define MDFB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define MDFB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/mdfb_pkg.sv -----
// Types, register indexes and the CRC helper for the frame builder.
package mdfb_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 16;

   localparam logic [CsrIndexWidth-1:0] CSR_FRAME_CONTROL  = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_SEQ_START      = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_DEST_PAN       = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_DEST_ADDRESS   = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_SOURCE_ADDRESS = 3'd4;

   localparam logic [15:0] CRC_POLY_REFL = 16'h8408;

   // Position of the byte being emitted within the frame.
   typedef enum logic [3:0] {
      STEP_FC_LO,
      STEP_FC_HI,
      STEP_SEQ,
      STEP_PAN_LO,
      STEP_PAN_HI,
      STEP_DST_LO,
      STEP_DST_HI,
      STEP_SRC_LO,
      STEP_SRC_HI,
      STEP_PAYLOAD,
      STEP_CRC_LO,
      STEP_CRC_HI
   } step_type;

   // Header fields held by the register block.
   typedef struct packed {
      logic [15:0] frame_control;
      logic [15:0] dest_pan;
      logic [15:0] dest_address;
      logic [15:0] source_address;
   } cfg_type;

   // Load request for the sequence counter.
   typedef struct packed {
      logic       load;
      logic [7:0] value;
   } seq_load_type;

   // One frame byte handed to the output stage.
   typedef struct packed {
      logic       valid;
      logic [7:0] frame_byte;
      logic       frame_end;
   } emit_type;

   // Reflected CRC-16 update over one byte, LSB first.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int k = 0; k < 8; k++) begin
         fb = data[k] ^ c[0];
         c  = {1'b0, c[15:1]};
         if (fb) begin
            c = c ^ CRC_POLY_REFL;
         end
      end
      return c;
   endfunction

endpackage

// ----- hw/rtl/mdfb_if.sv -----
// Valid/ready channel interfaces for payload requests and frame responses.
interface mdfb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       last_byte;
   logic       no_payload;

   modport source (output valid, output payload_byte, output last_byte, output no_payload,
                   input ready);
   modport sink (input valid, input payload_byte, input last_byte, input no_payload,
                 output ready);
endinterface

interface mdfb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;

   modport source (output valid, output frame_byte, output frame_end, input ready);
   modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

// ----- hw/rtl/mdfb_csr.sv -----
// Configuration register file holding the header fields.
module mdfb_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [mdfb_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [mdfb_pkg::CsrDataWidth-1:0]    csr_write_data,
   output mdfb_pkg::cfg_type                    cfg,
   output mdfb_pkg::seq_load_type               seq_load
);
   import mdfb_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write into the addressed field; unknown indexes are dropped.
   always_comb begin
      cfg_in         = cfg_ff;
      seq_load.load  = 1'b0;
      seq_load.value = csr_write_data[7:0];
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FRAME_CONTROL:  cfg_in.frame_control  = csr_write_data;
            CSR_SEQ_START:      seq_load.load         = 1'b1;
            CSR_DEST_PAN:       cfg_in.dest_pan       = csr_write_data;
            CSR_DEST_ADDRESS:   cfg_in.dest_address   = csr_write_data;
            CSR_SOURCE_ADDRESS: cfg_in.source_address = csr_write_data;
            default:            cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hw/rtl/mdfb_framer.sv -----
// Item register and byte sequencer: header, payload pass-through and CRC.
`include "mac_data_frame_builder_macros.svh"

module mdfb_framer (
   input  logic                    clock,
   input  logic                    reset,
   mdfb_req_if.sink                req_chan,
   input  mdfb_pkg::cfg_type       cfg,
   input  mdfb_pkg::seq_load_type  seq_load,
   input  logic                    out_free,
   output mdfb_pkg::emit_type      emit
);
   import mdfb_pkg::*;

   logic        item_valid_ff, item_valid_in;
   logic [7:0]  payload_ff, payload_in;
   logic        last_ff, last_in;
   logic        none_ff, none_in;
   step_type    step_ff, step_in;
   logic        in_frame_ff, in_frame_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  seq_ff, seq_in;

   logic        fire;
   logic        final_step;
   logic        done;
   logic        accept;
   logic [7:0]  cur_byte;

   // Select the byte for the current step.
   always_comb begin
      unique case (step_ff)
         STEP_FC_LO:   cur_byte = cfg.frame_control[7:0];
         STEP_FC_HI:   cur_byte = cfg.frame_control[15:8];
         STEP_SEQ:     cur_byte = seq_ff;
         STEP_PAN_LO:  cur_byte = cfg.dest_pan[7:0];
         STEP_PAN_HI:  cur_byte = cfg.dest_pan[15:8];
         STEP_DST_LO:  cur_byte = cfg.dest_address[7:0];
         STEP_DST_HI:  cur_byte = cfg.dest_address[15:8];
         STEP_SRC_LO:  cur_byte = cfg.source_address[7:0];
         STEP_SRC_HI:  cur_byte = cfg.source_address[15:8];
         STEP_PAYLOAD: cur_byte = payload_ff;
         STEP_CRC_LO:  cur_byte = crc_ff[7:0];
         STEP_CRC_HI:  cur_byte = crc_ff[15:8];
         default:      cur_byte = 8'h00;
      endcase
   end

   assign fire       = item_valid_ff && out_free;
   assign final_step = ((step_ff == STEP_PAYLOAD) && !last_ff) || (step_ff == STEP_CRC_HI);
   assign done       = fire && final_step;
   assign req_chan.ready = !item_valid_ff || done;
   assign accept     = req_chan.valid && req_chan.ready;

   assign emit.valid      = fire;
   assign emit.frame_byte = cur_byte;
   assign emit.frame_end  = (step_ff == STEP_CRC_HI);

   // Update frame state, CRC and sequence number as bytes are emitted; a CSR load sets the sequence number.
   always_comb begin
      in_frame_in = in_frame_ff;
      crc_in      = crc_ff;
      seq_in      = seq_ff;
      if (fire) begin
         if (step_ff == STEP_FC_LO) begin
            in_frame_in = 1'b1;
            crc_in      = crc_byte(16'h0000, cur_byte);
         end else if (step_ff == STEP_CRC_HI) begin
            in_frame_in = 1'b0;
            crc_in      = 16'h0000;
         end else if (step_ff != STEP_CRC_LO) begin
            crc_in      = crc_byte(crc_ff, cur_byte);
         end
         if (step_ff == STEP_SEQ) begin
            seq_in = seq_ff + 8'd1;
         end
      end
      if (seq_load.load) begin
         seq_in = seq_load.value;
      end
   end

   // Hold or replace the item; pick the next step.
   always_comb begin
      item_valid_in = item_valid_ff;
      payload_in    = payload_ff;
      last_in       = last_ff;
      none_in       = none_ff;
      step_in       = step_ff;
      if (accept) begin
         item_valid_in = 1'b1;
         payload_in    = req_chan.payload_byte;
         last_in       = req_chan.last_byte;
         none_in       = req_chan.no_payload;
         if (!in_frame_in) begin
            step_in = STEP_FC_LO;
         end else if (req_chan.no_payload) begin
            step_in = STEP_CRC_LO;
         end else begin
            step_in = STEP_PAYLOAD;
         end
      end else if (done) begin
         item_valid_in = 1'b0;
      end else if (fire) begin
         priority case (step_ff)
            STEP_SRC_HI:  step_in = none_ff ? STEP_CRC_LO : STEP_PAYLOAD;
            STEP_PAYLOAD: step_in = STEP_CRC_LO;
            default:      step_in = step_type'(step_ff + 4'd1);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         step_ff       <= STEP_FC_LO;
         in_frame_ff   <= 1'b0;
         crc_ff        <= 16'h0000;
         seq_ff        <= 8'h00;
      end else begin
         item_valid_ff <= item_valid_in;
         step_ff       <= step_in;
         in_frame_ff   <= in_frame_in;
         crc_ff        <= crc_in;
         seq_ff        <= seq_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
      last_ff    <= last_in;
      none_ff    <= none_in;
   end

   `MDFB_ASSERT_NOW(a_header_first, item_valid_ff && !in_frame_ff, step_ff == STEP_FC_LO, "item outside a frame must start at the header")
   `MDFB_ASSERT_NEXT(a_crc_pair, fire && (step_ff == STEP_CRC_LO), item_valid_ff && (step_ff == STEP_CRC_HI), "CRC low byte not followed by CRC high byte")
   `MDFB_ASSERT_NEXT(a_seq_advance, fire && (step_ff == STEP_SEQ) && !seq_load.load, seq_ff == $past(seq_ff) + 8'd1, "sequence number did not advance after header")
   `MDFB_ASSERT_NEXT(a_crc_cleared, fire && (step_ff == STEP_CRC_HI), !in_frame_ff && (crc_ff == 16'h0000), "frame state not cleared after CRC")

endmodule

// ----- hw/rtl/mdfb_out_stage.sv -----
// Output register stage driving the response channel.
module mdfb_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  mdfb_pkg::emit_type  emit,
   output logic                out_free,
   mdfb_rsp_if.source          rsp_chan
);
   import mdfb_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       end_ff, end_in;

   // Load a new byte whenever the register is empty or being drained.
   assign out_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      end_in   = end_ff;
      if (out_free) begin
         valid_in = emit.valid;
         if (emit.valid) begin
            byte_in = emit.frame_byte;
            end_in  = emit.frame_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      end_ff  <= end_in;
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.frame_byte = byte_ff;
   assign rsp_chan.frame_end  = end_ff;

endmodule

// ----- hw/rtl/mac_data_frame_builder.sv -----
// Top level of the MAC data frame builder.
//
// req_chan carries one payload byte per transfer with last_byte and no_payload
// flags; rsp_chan returns the frame one byte per transfer, frame_end marking
// the high CRC byte. The csr_ port writes frame_control, seq_start, dest_pan,
// dest_address and source_address by index 0..4; write only while idle.
// The first item of a frame emits the 9-byte header (sequence number counts
// up per frame), then the payload byte if any; closing items append the CRC-16.
// The first byte of an accepted item passes the item register, then the
// output register, before rsp_chan offers it. Throughput, set by the single
// output register: one result byte per cycle unless rsp_chan stalls. An item
// yields 1 byte mid-frame, 3 for a last byte, up to 12 for the first item
// of a frame; the next item is accepted as the current one's final byte fires.
// Reset clears the valid flags, step, header registers, sequence counter, CRC and frame state.
// When the receiver stalls, the output register holds its byte and the item
// register holds the current item; req_chan.ready drops until it drains.
module mac_data_frame_builder (
   input  logic                                clock,
   input  logic                                reset,
   mdfb_req_if.sink                            req_chan,
   mdfb_rsp_if.source                          rsp_chan,
   input  logic                                csr_write_enable,
   input  logic [mdfb_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [mdfb_pkg::CsrDataWidth-1:0]   csr_write_data
);
   import mdfb_pkg::*;

   cfg_type      cfg;
   seq_load_type seq_load;
   emit_type     emit;
   logic         out_free;

   mdfb_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg),
      .seq_load         (seq_load)
   );

   mdfb_framer u_framer (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .cfg      (cfg),
      .seq_load (seq_load),
      .out_free (out_free),
      .emit     (emit)
   );

   mdfb_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .emit     (emit),
      .out_free (out_free),
      .rsp_chan (rsp_chan)
   );

endmodule
